// ----- rtl/core/eawa_pkg.sv -----
// ----------------------------------------------------------------------------
// eawa_pkg: shared types and constants
// Beat layouts, field widths and register indexes for the energy meter
// with running window average.
// ----------------------------------------------------------------------------
package eawa_pkg;

  // Field widths
  localparam int PWR_W      = 16;  // power sample
  localparam int NOW_W      = 64;  // microsecond timestamp
  localparam int WIN_W      = 16;  // window length in ms
  localparam int SAVE_W     = 32;  // save interval in us
  localparam int TOTAL_W    = 48;  // total_energy field
  localparam int WFIG_W     = 32;  // window_energy field
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Whole-ms conversion
  localparam int US_PER_MS = 1000;
  localparam int US_REM_W  = 10;   // remainder < 1000

  // Energy increment clamps ms at 2^48
  localparam int EMS_W = 49;

  // Iteration counter, long enough for the 64-step ms divide
  localparam int CNT_W = 6;

  // Register reset values
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd5000;
  localparam logic [SAVE_W-1:0] SAVE_RESET   = 32'd5000000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAVE_INTERVAL = 1'd1;

  typedef struct packed {
    logic signed [PWR_W-1:0] power_sample;
    logic [NOW_W-1:0]        now_us;
  } in_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_energy;
    logic signed [WFIG_W-1:0]  window_energy;
    logic                      updated;
    logic                      save_request;
  } out_t;

endpackage

// ----- rtl/core/energy_accumulator_window_average_unit.sv -----
// ----------------------------------------------------------------------------
// energy_accumulator_window_average_unit: energy meter with window average
// Accumulates power * elapsed ms into a saturating total, keeps a running
// per-ms average over a growing window, and flags periodic save requests.
// ----------------------------------------------------------------------------
// Each sample beat runs the us-to-ms divide; when at least one whole ms passed,
// the energy and average products, the total saturation and, if the gap is
// shorter than the window, the average divide follow; then the window product
// and the result beat. One item at a time: a new beat is taken only after the
// last result is loaded. Bit-serial loops: 64 steps for the us-to-ms divide,
// SUM_W steps for the average divide, 16 steps each for the two multiply passes.
// Reset (synchronous, rst high) clears total, average, fill length and both
// timestamps, and loads window_ms = 5000 and save_interval_us = 5000000.
// ----------------------------------------------------------------------------
module energy_accumulator_window_average_unit
  import eawa_pkg::*;
#(
  parameter int ENERGY_BITS       = 48,
  parameter int AVG_FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Average holds a power value with AVG_FRACTION_BITS fraction bits.
  localparam int AVG_W = PWR_W + AVG_FRACTION_BITS;
  // avg * (len - ms) + scaled * ms, and later avg * window
  localparam int SUM_W = AVG_W + WIN_W + 1;
  // power * clamped ms
  localparam int INC_W = PWR_W + EMS_W;
  localparam int SAT_W = INC_W + 1;

  localparam logic signed [SAT_W-1:0] EMAX =
    {{(SAT_W-ENERGY_BITS+1){1'b0}}, {(ENERGY_BITS-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] EMIN = ~EMAX;
  localparam logic signed [SUM_W-1:0] WMAX =
    {{(SUM_W-WFIG_W+1){1'b0}}, {(WFIG_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] WMIN = ~WMAX;
  localparam logic signed [SUM_W-1:0] FRAC_MASK =
    {{(SUM_W-AVG_FRACTION_BITS){1'b0}}, {AVG_FRACTION_BITS{1'b1}}};

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a sample beat
  localparam logic [2:0] S_MSDIV = 3'd1;  // elapsed us / 1000, one bit a cycle
  localparam logic [2:0] S_CHECK = 3'd2;  // window clamp, save check, load mults
  localparam logic [2:0] S_MUL   = 3'd3;  // energy and average products
  localparam logic [2:0] S_POST  = 3'd4;  // saturate total, set up divide
  localparam logic [2:0] S_ADIV  = 3'd5;  // sum / len, one bit a cycle
  localparam logic [2:0] S_WLOAD = 3'd6;  // start avg * window on S_MUL's datapath
  localparam logic [2:0] S_DONE  = 3'd7;  // hold until the result register frees

  // ---------------------------------------------------------------- state
  logic [2:0]                    state;
  logic                          wmul;      // S_MUL is running the window product

  // configuration
  logic [WIN_W-1:0]              window_ms;
  logic [SAVE_W-1:0]             save_interval_us;

  // architectural state
  logic signed [ENERGY_BITS-1:0] energy_total;
  logic signed [AVG_W-1:0]       avg_per_ms;
  logic [WIN_W-1:0]              filled_ms;
  logic [NOW_W-1:0]              last_sample_us;
  logic [NOW_W-1:0]              last_save_us;

  // per-item datapath
  logic signed [PWR_W-1:0]       power;
  logic [NOW_W-1:0]              now;
  logic [CNT_W-1:0]              cnt;
  logic [NOW_W-1:0]              ms_div;    // elapsed us in, whole ms out
  logic [US_REM_W-1:0]           ms_rem;
  logic                          upd;
  logic                          save;
  logic                          full;      // gap covers the whole window
  logic [WIN_W-1:0]              len;
  logic signed [INC_W-1:0]       e_mc;
  logic [PWR_W-1:0]              e_mp;
  logic signed [INC_W-1:0]       e_acc;
  logic signed [SUM_W-1:0]       a_mc;
  logic signed [SUM_W-1:0]       s_mc;
  logic [WIN_W-1:0]              k_mp;
  logic [WIN_W-1:0]              m_mp;
  logic signed [SUM_W-1:0]       a_acc;
  logic [SUM_W-1:0]              dv;        // |sum| in, quotient out
  logic [WIN_W-1:0]              dv_rem;
  logic                          neg;

  // ---------------------------------------------------------------- comb
  logic [US_REM_W:0]             ms_r2;
  logic                          ms_ge;
  logic [NOW_W-1:0]              ms_div_next;
  logic [US_REM_W-1:0]           ms_rem_next;

  logic [WIN_W:0]                dv_r2;
  logic                          dv_ge;
  logic [SUM_W-1:0]              dv_next;
  logic [WIN_W-1:0]              dv_rem_next;

  logic [WIN_W-1:0]              weff;
  logic                          ms_nz;
  logic                          ms_full;
  logic [WIN_W-1:0]              ms16;
  logic [WIN_W:0]                fsum;
  logic [WIN_W-1:0]              len_c;
  logic [NOW_W-1:0]              since_save;
  logic                          ms_big;
  logic [EMS_W-1:0]              ems;
  logic signed [AVG_W-1:0]       scaled;

  logic signed [INC_W-1:0]       e_add;
  logic signed [SUM_W-1:0]       a_add;
  logic signed [SAT_W-1:0]       e_sum;
  logic signed [SAT_W-1:0]       e_sat;
  logic signed [SUM_W-1:0]       a_mag;

  logic signed [SUM_W-1:0]       w_adj;
  logic signed [SUM_W-1:0]       w_quo;
  logic signed [WFIG_W-1:0]      w_fig;
  logic                          out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // restoring divide by 1000
  always_comb begin
    ms_r2       = {ms_rem, ms_div[NOW_W-1]};
    ms_ge       = (ms_r2 >= (US_REM_W+1)'(US_PER_MS));
    ms_rem_next = ms_ge ? US_REM_W'(ms_r2 - (US_REM_W+1)'(US_PER_MS))
                        : ms_r2[US_REM_W-1:0];
    ms_div_next = {ms_div[NOW_W-2:0], ms_ge};
  end

  // restoring divide by the clamped window length
  always_comb begin
    dv_r2       = {dv_rem, dv[SUM_W-1]};
    dv_ge       = (dv_r2 >= {1'b0, len});
    dv_rem_next = dv_ge ? WIN_W'(dv_r2 - {1'b0, len}) : dv_r2[WIN_W-1:0];
    dv_next     = {dv[SUM_W-2:0], dv_ge};
  end

  // window clamp and save check, used in S_CHECK
  always_comb begin
    weff       = (window_ms == '0) ? WIN_W'(1) : window_ms;
    ms_nz      = |ms_div;
    ms16       = ms_div[WIN_W-1:0];
    ms_full    = (|ms_div[NOW_W-1:WIN_W]) || (ms16 >= weff);
    fsum       = {1'b0, filled_ms} + {1'b0, ms16};
    len_c      = (fsum > {1'b0, weff}) ? weff : fsum[WIN_W-1:0];
    since_save = now - last_save_us;
    // ms above 2^48 is clamped for the energy increment
    ms_big     = (|ms_div[NOW_W-1:EMS_W]) ||
                 (ms_div[EMS_W-1] && (|ms_div[EMS_W-2:0]));
    ems        = ms_big ? {1'b1, {(EMS_W-1){1'b0}}} : ms_div[EMS_W-1:0];
    scaled     = {power, {AVG_FRACTION_BITS{1'b0}}};
  end

  // shift-add steps; the power MSB carries negative weight
  always_comb begin
    e_add = '0;
    if (e_mp[0]) begin
      e_add = (cnt == '0) ? -e_mc : e_mc;
    end
    a_add = (k_mp[0] ? a_mc : SUM_W'(0)) + (m_mp[0] ? s_mc : SUM_W'(0));
  end

  // saturating total and divide setup
  always_comb begin
    e_sum = SAT_W'(energy_total) + SAT_W'(e_acc);
    if (e_sum > EMAX) begin
      e_sat = EMAX;
    end else if (e_sum < EMIN) begin
      e_sat = EMIN;
    end else begin
      e_sat = e_sum;
    end
    a_mag = a_acc[SUM_W-1] ? -a_acc : a_acc;
  end

  // window figure: avg * window / 2^F toward zero, clamped to 32 bits
  always_comb begin
    w_adj = a_acc + (a_acc[SUM_W-1] ? FRAC_MASK : SUM_W'(0));
    w_quo = w_adj >>> AVG_FRACTION_BITS;
    if (w_quo > WMAX) begin
      w_fig = WFIG_W'(WMAX);
    end else if (w_quo < WMIN) begin
      w_fig = WFIG_W'(WMIN);
    end else begin
      w_fig = WFIG_W'(w_quo);
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      wmul             <= 1'b0;
      out_valid        <= 1'b0;
      window_ms        <= WINDOW_RESET;
      save_interval_us <= SAVE_RESET;
      energy_total     <= '0;
      avg_per_ms       <= '0;
      filled_ms        <= '0;
      last_sample_us   <= '0;
      last_save_us     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_MS:     window_ms        <= cfg_data[WIN_W-1:0];
          REG_SAVE_INTERVAL: save_interval_us <= cfg_data[SAVE_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MSDIV;
          end
        end
        S_MSDIV: begin
          if (cnt == '0) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ms_nz) begin
            last_sample_us <= now;
            if (since_save > NOW_W'(save_interval_us)) begin
              last_save_us <= now;
            end
            wmul  <= 1'b0;
            state <= S_MUL;
          end else begin
            state <= S_WLOAD;
          end
        end
        S_MUL: begin
          if (cnt == '0) begin
            state <= wmul ? S_DONE : S_POST;
          end
        end
        S_POST: begin
          energy_total <= ENERGY_BITS'(e_sat);
          if (full) begin
            avg_per_ms <= scaled;
            filled_ms  <= weff;
            state      <= S_WLOAD;
          end else begin
            filled_ms  <= len;
            state      <= S_ADIV;
          end
        end
        S_ADIV: begin
          if (cnt == '0) begin
            avg_per_ms <= neg ? -AVG_W'(dv_next) : AVG_W'(dv_next);
            state      <= S_WLOAD;
          end
        end
        S_WLOAD: begin
          wmul  <= 1'b1;
          state <= S_MUL;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        power  <= in_data.power_sample;
        now    <= in_data.now_us;
        ms_div <= in_data.now_us - last_sample_us;
        ms_rem <= '0;
        cnt    <= CNT_W'(NOW_W - 1);
      end
      S_MSDIV: begin
        ms_div <= ms_div_next;
        ms_rem <= ms_rem_next;
        cnt    <= cnt - CNT_W'(1);
      end
      S_CHECK: begin
        upd   <= ms_nz;
        save  <= ms_nz && (since_save > NOW_W'(save_interval_us));
        full  <= ms_full;
        len   <= len_c;
        e_mc  <= INC_W'(ems);
        e_mp  <= power;
        e_acc <= '0;
        a_mc  <= SUM_W'(avg_per_ms);
        s_mc  <= SUM_W'(scaled);
        k_mp  <= len_c - ms16;
        m_mp  <= ms16;
        a_acc <= '0;
        cnt   <= CNT_W'(WIN_W - 1);
      end
      S_MUL: begin
        if (!wmul) begin
          e_acc <= e_acc + e_add;
          e_mc  <= e_mc <<< 1;
          e_mp  <= e_mp >> 1;
        end
        a_acc <= a_acc + a_add;
        a_mc  <= a_mc <<< 1;
        s_mc  <= s_mc <<< 1;
        k_mp  <= k_mp >> 1;
        m_mp  <= m_mp >> 1;
        cnt   <= cnt - CNT_W'(1);
      end
      S_POST: begin
        neg    <= a_acc[SUM_W-1];
        dv     <= a_mag;
        dv_rem <= '0;
        cnt    <= CNT_W'(SUM_W - 1);
      end
      S_ADIV: begin
        dv     <= dv_next;
        dv_rem <= dv_rem_next;
        cnt    <= cnt - CNT_W'(1);
      end
      S_WLOAD: begin
        a_mc  <= SUM_W'(avg_per_ms);
        k_mp  <= weff;
        m_mp  <= '0;
        a_acc <= '0;
        cnt   <= CNT_W'(WIN_W - 1);
      end
      S_DONE: begin
        if (out_load) begin
          out_data.total_energy  <= TOTAL_W'(energy_total);
          out_data.window_energy <= w_fig;
          out_data.updated       <= upd;
          out_data.save_request  <= save;
        end
      end
      default: ;
    endcase
  end

endmodule
